### src/hlhs_pkg.sv
// ----------------------------------------------------------------------------
// hlhs_pkg
// Shared types and constants of the heartbeat link health selector.
// ----------------------------------------------------------------------------
package hlhs_pkg;

  localparam int unsigned SCORE_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LOCAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REMOTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_ID   = 2'd2;

  localparam logic [2:0]  NUM_LOCAL_RST  = 3'd1;
  localparam logic [2:0]  NUM_REMOTE_RST = 3'd1;
  localparam logic [15:0] ASSOC_ID_RST   = 16'hFFFF;

  localparam logic [SCORE_W:0]   HEALTH_LIMIT = 6'd6;
  localparam logic [SCORE_W-1:0] SCORE_CAP    = 5'd15;
  localparam logic [SCORE_W-1:0] PENALTY      = 5'd3;

  typedef struct packed {
    logic       opcode;
    logic [3:0] ack_link;
  } hlhs_in_t;

  typedef struct packed {
    logic        primary_notice;
    logic [1:0]  local_index;
    logic [1:0]  remote_index;
    logic [3:0]  link_index;
    logic [15:0] assoc_out;
    logic [3:0]  preferred_link;
    logic        last;
  } hlhs_out_t;

  typedef struct packed {
    logic               pend;
    logic [SCORE_W-1:0] score;
  } hlhs_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREF_RD,
    ST_PREF_CHK,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_AGE_RD,
    ST_AGE_WR,
    ST_ACK_RD,
    ST_ACK_WR
  } hlhs_state_e;

  typedef enum logic [1:0] {
    ADDR_PREF,
    ADDR_ACK,
    ADDR_CNT
  } hlhs_addr_e;

  typedef struct packed {
    logic       take;
    logic       rd_en;
    hlhs_addr_e addr_sel;
    logic       cnt_clr;
    logic       best_load;
    logic       scan_step;
    logic       age_step;
    logic       ack_wr;
  } hlhs_cmd_t;

  typedef struct packed {
    logic is_ack;
    logic ack_ok;
    logic no_links;
    logic pref_bad;
    logic last_link;
    logic out_free;
  } hlhs_stat_t;

endpackage

### src/heartbeat_link_health_selector.sv
// ----------------------------------------------------------------------------
// heartbeat_link_health_selector
// An acknowledgement reads and then writes back its link entry, or does nothing
// when its link is out of range; no beat. A tick checks the preferred link,
// scans all links when the check calls for it, then ages each link in turn with
// one result beat per link, waiting while the output register holds an untaken beat.
// One item is in work at a time; a finished beat waits in the output register.
// Reset clears all link entries at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module heartbeat_link_health_selector
  import hlhs_pkg::*;
#(
  parameter int unsigned MAX_LOCAL  = 4,
  parameter int unsigned MAX_REMOTE = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hlhs_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hlhs_out_t             out_data_o
);

  hlhs_cmd_t  cmd;
  hlhs_stat_t stat;

  hlhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hlhs_dpath #(
    .MAX_LOCAL  (MAX_LOCAL),
    .MAX_REMOTE (MAX_REMOTE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign in_ready_o = cmd.take;

endmodule

### src/hlhs_ctrl.sv
// ----------------------------------------------------------------------------
// hlhs_ctrl
// Sequencer that steps the datapath through acknowledgements and ticks.
// ----------------------------------------------------------------------------
module hlhs_ctrl
  import hlhs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  hlhs_stat_t stat_i,
  output hlhs_cmd_t  cmd_o
);

  hlhs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.is_ack) begin
            state_d = stat_i.ack_ok ? ST_ACK_RD : ST_IDLE;
          end else begin
            state_d = ST_PREF_RD;
          end
        end
      end
      ST_PREF_RD: state_d = ST_PREF_CHK;
      ST_PREF_CHK: begin
        if (stat_i.no_links) begin
          state_d = ST_IDLE;
        end else if (stat_i.pref_bad) begin
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_AGE_RD;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = stat_i.last_link ? ST_AGE_RD : ST_SCAN_RD;
      ST_AGE_RD: state_d = ST_AGE_WR;
      ST_AGE_WR: begin
        if (stat_i.out_free) begin
          state_d = stat_i.last_link ? ST_IDLE : ST_AGE_RD;
        end
      end
      ST_ACK_RD: state_d = ST_ACK_WR;
      ST_ACK_WR: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.addr_sel = ADDR_CNT;
    unique case (state_q)
      ST_IDLE: cmd_o.take = in_valid_i;
      ST_PREF_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr_sel = ADDR_PREF;
      end
      ST_PREF_CHK: begin
        cmd_o.cnt_clr = 1'b1;
        cmd_o.best_load = 1'b1;
      end
      ST_SCAN_RD: cmd_o.rd_en = 1'b1;
      ST_SCAN_CMP: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.cnt_clr = stat_i.last_link;
      end
      ST_AGE_RD: cmd_o.rd_en = 1'b1;
      ST_AGE_WR: cmd_o.age_step = stat_i.out_free;
      ST_ACK_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr_sel = ADDR_ACK;
      end
      ST_ACK_WR: begin
        cmd_o.ack_wr = 1'b1;
        cmd_o.addr_sel = ADDR_ACK;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### src/hlhs_dpath.sv
// ----------------------------------------------------------------------------
// hlhs_dpath
// Link table, configuration, counters, selection state and result register.
// ----------------------------------------------------------------------------
module hlhs_dpath
  import hlhs_pkg::*;
#(
  parameter int unsigned MAX_LOCAL  = 4,
  parameter int unsigned MAX_REMOTE = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  hlhs_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hlhs_out_t             out_data_o,
  input  hlhs_cmd_t             cmd_i,
  output hlhs_stat_t            stat_o
);

  localparam int unsigned LINKS = MAX_LOCAL * MAX_REMOTE;
  localparam int unsigned IW    = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int unsigned KW    = $clog2(LINKS + 1);
  localparam int unsigned LCW   = $clog2(MAX_LOCAL + 1);
  localparam int unsigned RCW   = $clog2(MAX_REMOTE + 1);
  localparam int unsigned LIW   = (MAX_LOCAL > 1) ? $clog2(MAX_LOCAL) : 1;
  localparam int unsigned RIW   = (MAX_REMOTE > 1) ? $clog2(MAX_REMOTE) : 1;

  logic [2:0]  num_local_q, num_remote_q;
  logic [15:0] assoc_q;

  logic [LCW-1:0]     eff_local;
  logic [RCW-1:0]     eff_remote;
  logic [LCW+RCW-1:0] link_prod;
  logic [KW-1:0]      links;

  logic [KW-1:0]      k_q;
  logic [LIW-1:0]     i_q;
  logic [RIW-1:0]     j_q;
  logic [IW-1:0]      pref_q;
  logic [SCORE_W-1:0] best_q;
  logic               notify_q;
  logic [3:0]         ack_q;

  hlhs_entry_t        mem_q [LINKS];
  logic [LINKS-1:0]   valid_q;
  hlhs_entry_t        rd_data_q;
  logic               rd_valid_q;
  hlhs_entry_t        ent;

  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      cnt_addr;
  logic               mem_we;
  logic [IW-1:0]      wr_addr;
  hlhs_entry_t        wr_data;
  logic [SCORE_W-1:0] aged_score;
  logic [SCORE_W:0]   health;
  logic               prim;

  logic               out_valid_q;
  hlhs_out_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_local_q  <= NUM_LOCAL_RST;
      num_remote_q <= NUM_REMOTE_RST;
      assoc_q      <= ASSOC_ID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUM_LOCAL:  num_local_q  <= cfg_wdata_i[2:0];
        CFG_NUM_REMOTE: num_remote_q <= cfg_wdata_i[2:0];
        CFG_ASSOC_ID:   assoc_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign eff_local  = (int'(num_local_q) > MAX_LOCAL) ? LCW'(MAX_LOCAL) : LCW'(num_local_q);
  assign eff_remote = (int'(num_remote_q) > MAX_REMOTE) ? RCW'(MAX_REMOTE)
                                                        : RCW'(num_remote_q);
  assign link_prod  = (LCW+RCW)'(eff_local) * (LCW+RCW)'(eff_remote);
  assign links      = KW'(link_prod);

  assign cnt_addr = IW'(k_q);
  assign ent      = rd_valid_q ? rd_data_q : '0;

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_PREF: rd_addr = pref_q;
      ADDR_ACK:  rd_addr = IW'(ack_q);
      ADDR_CNT:  rd_addr = cnt_addr;
      default:   rd_addr = cnt_addr;
    endcase
  end

  always_comb begin
    if (ent.pend) begin
      aged_score = (ent.score < SCORE_CAP) ? ent.score + PENALTY : ent.score;
    end else begin
      aged_score = (ent.score != '0) ? ent.score - 1'b1 : ent.score;
    end
  end

  assign mem_we  = cmd_i.age_step || cmd_i.ack_wr;
  assign wr_addr = cmd_i.ack_wr ? IW'(ack_q) : cnt_addr;
  assign wr_data = cmd_i.ack_wr ? '{pend: 1'b0, score: ent.score}
                                : '{pend: 1'b1, score: aged_score};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ack_q <= in_data_i.ack_link;
    end
    if (cmd_i.best_load) begin
      best_q <= ent.score;
    end else if (cmd_i.scan_step && (ent.score < best_q)) begin
      best_q <= ent.score;
    end
  end

  assign prim = cmd_i.age_step && (cnt_addr == pref_q) && notify_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pref_q   <= '0;
      notify_q <= 1'b1;
    end else if (cmd_i.scan_step && (ent.score < best_q)) begin
      pref_q   <= cnt_addr;
      notify_q <= 1'b1;
    end else if (prim) begin
      notify_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.scan_step) begin
      k_q <= k_q + 1'b1;
    end else if (cmd_i.age_step) begin
      k_q <= k_q + 1'b1;
      if (int'(j_q) + 1 == int'(eff_remote)) begin
        j_q <= '0;
        i_q <= i_q + 1'b1;
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.age_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.age_step) begin
      out_q.primary_notice <= prim;
      out_q.local_index    <= 2'(i_q);
      out_q.remote_index   <= 2'(j_q);
      out_q.link_index     <= 4'(k_q);
      out_q.assoc_out      <= assoc_q;
      out_q.preferred_link <= 4'(pref_q);
      out_q.last           <= stat_o.last_link;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign health = {1'b0, ent.score} + (ent.pend ? {1'b0, PENALTY} : '0);

  assign stat_o.is_ack    = in_data_i.opcode;
  assign stat_o.ack_ok    = int'(in_data_i.ack_link) < int'(links);
  assign stat_o.no_links  = (links == '0);
  assign stat_o.pref_bad  = (health > HEALTH_LIMIT) || (pref_q != '0);
  assign stat_o.last_link = (KW'(k_q + 1'b1) == links);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### verif/hlhs_heartbeat_checker.sv
// ----------------------------------------------------------------------------
// Heartbeat link health selector checker
// Watches the configuration port and both beat channels of the block. It keeps
// its own copy of the link scores, pending flags, preferred link and notice
// flag, predicts the heartbeat beats of every accepted tick, and compares each
// accepted output beat, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
package hlhs_tb_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  localparam logic [hlhs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

endpackage

module hlhs_heartbeat_checker
  import hlhs_pkg::*;
  import hlhs_tb_pkg::*;
#(
  parameter int unsigned MAX_LOCAL  = 4,
  parameter int unsigned MAX_REMOTE = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  hlhs_in_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  hlhs_out_t             out_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           open_beats_o
);

  logic [SCORE_W-1:0] score_q [16];
  logic               pend_q [16];
  logic [3:0]         pref_q;
  logic               notice_q;
  logic [2:0]         num_local_q;
  logic [2:0]         num_remote_q;
  logic [15:0]        assoc_q;
  hlhs_out_t          heartbeat_q [$];

  task automatic clear_state();
    for (int k = 0; k < 16; k++) begin
      score_q[k] = '0;
      pend_q[k] = 1'b0;
    end
    pref_q = '0;
    notice_q = 1'b1;
    num_local_q = NUM_LOCAL_RST;
    num_remote_q = NUM_REMOTE_RST;
    assoc_q = ASSOC_ID_RST;
    heartbeat_q.delete();
  endtask

  function automatic int unsigned local_count();
    return (num_local_q > MAX_LOCAL) ? MAX_LOCAL : num_local_q;
  endfunction

  function automatic int unsigned remote_count();
    return (num_remote_q > MAX_REMOTE) ? MAX_REMOTE : num_remote_q;
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_NUM_LOCAL: begin
        num_local_q = value[2:0];
      end
      CFG_NUM_REMOTE: begin
        num_remote_q = value[2:0];
      end
      CFG_ASSOC_ID: begin
        assoc_q = value[15:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic clear_ack(input logic [3:0] link);
    if (link < local_count() * remote_count()) begin
      pend_q[link] = 1'b0;
    end
  endtask

  task automatic predict_tick();
    int unsigned        nl;
    int unsigned        nr;
    int unsigned        links;
    int unsigned        k;
    logic [SCORE_W:0]   health;
    logic [3:0]         old_pref;
    logic [SCORE_W-1:0] best;
    hlhs_out_t          beat;
    nl = local_count();
    nr = remote_count();
    links = nl * nr;
    health = {1'b0, score_q[pref_q]} + (pend_q[pref_q] ? {1'b0, PENALTY} : '0);
    if (health > HEALTH_LIMIT || pref_q != 4'd0) begin
      old_pref = pref_q;
      best = score_q[pref_q];
      for (int i = 0; i < links; i++) begin
        if (score_q[i] < best) begin
          pref_q = 4'(i);
          best = score_q[i];
        end
      end
      if (pref_q != old_pref) begin
        notice_q = 1'b1;
      end
    end
    for (int l = 0; l < nl; l++) begin
      for (int r = 0; r < nr; r++) begin
        k = l * nr + r;
        if (pend_q[k]) begin
          if (score_q[k] < SCORE_CAP) begin
            score_q[k] = score_q[k] + PENALTY;
          end
        end else if (score_q[k] != '0) begin
          score_q[k] = score_q[k] - 1'b1;
        end
        pend_q[k] = 1'b1;
        beat.primary_notice = (k == pref_q) && notice_q;
        if (beat.primary_notice) begin
          notice_q = 1'b0;
        end
        beat.local_index = 2'(l);
        beat.remote_index = 2'(r);
        beat.link_index = 4'(k);
        beat.assoc_out = assoc_q;
        beat.preferred_link = pref_q;
        beat.last = (k + 1 == links);
        heartbeat_q.push_back(beat);
      end
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  task automatic check_beat(input hlhs_out_t got);
    hlhs_out_t want;
    if (heartbeat_q.size() == 0) begin
      fail_count_o++;
      $display("%0t: unexpected beat, expected none, actual %p", $time, got);
    end else begin
      want = heartbeat_q.pop_front();
      check_field("primary_notice", 16'(want.primary_notice), 16'(got.primary_notice));
      check_field("local_index", 16'(want.local_index), 16'(got.local_index));
      check_field("remote_index", 16'(want.remote_index), 16'(got.remote_index));
      check_field("link_index", 16'(want.link_index), 16'(got.link_index));
      check_field("assoc_out", want.assoc_out, got.assoc_out);
      check_field("preferred_link", 16'(want.preferred_link), 16'(got.preferred_link));
      check_field("last", 16'(want.last), 16'(got.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      fail_count_o = 0;
      open_beats_o <= 0;
    end else begin
      if (cfg_we_i) begin
        write_register(cfg_index_i, cfg_wdata_i);
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OP_ACK) begin
          clear_ack(in_data_i.ack_link);
        end else begin
          predict_tick();
        end
      end
      if (out_valid_i && out_ready_i) begin
        check_beat(out_data_i);
      end
      open_beats_o <= heartbeat_q.size();
    end
  end

endmodule

### verif/tb_heartbeat_link_health_selector.sv
// ----------------------------------------------------------------------------
// Heartbeat link health selector testbench
// Drives directed and random acknowledgement and tick beats under several link
// configurations, with random gaps on the input and random stalls on the
// output. A checker beside the block predicts and compares every heartbeat;
// this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_heartbeat_link_health_selector;
  import hlhs_pkg::*;
  import hlhs_tb_pkg::*;

  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned SETTLE_TICKS = 48;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_BEATS  = 28;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  hlhs_in_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  hlhs_out_t             out_data_o;
  int unsigned           fail_count;
  int unsigned           open_beats;
  bit                    calm_run = 1'b0;

  heartbeat_link_health_selector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  hlhs_heartbeat_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .open_beats_o (open_beats)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= calm_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic bit idle_roll();
    return !calm_run && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  task automatic send_beat(input logic op, input logic [3:0] link);
    hlhs_in_t item;
    item.opcode = op;
    item.ack_link = link;
    while (idle_roll()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic set_links(input logic [2:0] nl, input logic [2:0] nr,
                           input logic [15:0] assoc);
    write_reg(CFG_NUM_LOCAL, {13'd0, nl});
    write_reg(CFG_NUM_REMOTE, {13'd0, nr});
    write_reg(CFG_ASSOC_ID, assoc);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_beats != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  initial begin
    int unsigned nl;
    int unsigned nr;
    int unsigned links;
    int unsigned ack_odds;
    int unsigned counted;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(OP_TICK, 4'd0);
    send_beat(OP_TICK, 4'd15);
    send_beat(OP_TICK, 4'd0);
    send_beat(OP_ACK, 4'd15);
    send_beat(OP_ACK, 4'd0);
    send_beat(OP_TICK, 4'd0);
    send_beat(OP_TICK, 4'd0);
    send_beat(OP_TICK, 4'd0);
    settle();

    write_reg(CFG_SPARE, 16'hFFFF);
    set_links(3'd4, 3'd4, 16'h0000);
    send_beat(OP_ACK, 4'd15);
    send_beat(OP_ACK, 4'd5);
    send_beat(OP_TICK, 4'd0);
    send_beat(OP_ACK, 4'd1);
    send_beat(OP_ACK, 4'd2);
    send_beat(OP_TICK, 4'd0);
    settle();

    set_links(3'd0, 3'd4, 16'hFFFF);
    send_beat(OP_TICK, 4'd0);
    send_beat(OP_ACK, 4'd3);
    settle();

    set_links(3'd7, 3'd5, 16'hA5A5);
    send_beat(OP_ACK, 4'd15);
    send_beat(OP_TICK, 4'd0);
    send_beat(OP_ACK, 4'd15);
    send_beat(OP_TICK, 4'd0);
    settle();

    set_links(3'd1, 3'd2, 16'h5A5A);
    send_beat(OP_TICK, 4'd0);
    send_beat(OP_ACK, 4'd1);
    send_beat(OP_TICK, 4'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      nl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      nr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      set_links(3'(nl), 3'(nr), 16'($urandom));
      links = ((nl > 4) ? 4 : nl) * ((nr > 4) ? 4 : nr);
      calm_run = (phase == 3);
      ack_odds = $urandom_range(10, 95);
      counted = 0;
      while (counted < PHASE_BEATS) begin
        for (int k = 0; k < links; k++) begin
          if ($urandom_range(0, 99) < ack_odds) begin
            send_beat(OP_ACK, 4'(k));
            counted++;
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          send_beat(OP_ACK, 4'($urandom_range(0, 15)));
        end
        send_beat(OP_TICK, 4'($urandom));
        counted++;
      end
    end
    calm_run = 1'b0;
    settle();

    if (fail_count == 0 && open_beats == 0) begin
      $display("heartbeat_link_health_selector regression: pass");
    end else begin
      $display("heartbeat_link_health_selector regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("heartbeat_link_health_selector regression: fail");
    $finish;
  end

endmodule
